>>> rtl/core/epd_pkg.sv
`default_nettype none

package epd_pkg;

	// pipeline geometry
	localparam int CORDIC_N = 30;
	localparam int SQ1_K    = 31;
	localparam int SQ2_K    = 32;
	localparam int DIV_Q    = 34;

	// pi * 2^62, floor
	localparam logic [63:0] PI62 = 64'hC90FDAA22168C234;

	// half units of 1e-7 degree to Q2.30 rad, scaled by 2^32
	localparam logic [31:0] CA = 32'(PI62 / 64'd3600000000);

	// 1e-7 degree to centiradian Q30, scaled by 2^32, split for the multipliers
	localparam logic [39:0] CD    = 40'(PI62 / 64'd18000000);
	localparam logic [19:0] CD_HI = CD[39:20];
	localparam logic [19:0] CD_LO = CD[19:0];

	localparam logic [22:0] E2 = 23'((64'd1073741824 * 64'd6674 + 64'd500000) / 64'd1000000);

	localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;
	localparam logic [30:0] ONE30    = 31'd1073741824;
	localparam logic [29:0] HALF30   = 30'd536870912;

	// radii in m; the dividend is radius << 40, its top bits seed the divider
	localparam logic [63:0] RAD_N = 64'd6377397;
	localparam logic [63:0] RAD_M = 64'd6334834;
	localparam logic [30:0] N_R0  = 31'(RAD_N << (40 - DIV_Q));
	localparam logic [30:0] M_R0  = 31'(RAD_M << (40 - DIV_Q));

	localparam logic [32:0] DIST_MAX = 33'd4500000000;
	localparam logic [31:0] H_FOLD   = 32'd1800000000;
	localparam logic [31:0] H_WRAP   = 32'd3600000000;

	function automatic logic [29:0] epd_atan(input int unsigned i);
		logic [29:0] r;
		case (i)
			0:       r = 30'h3243F6A8;
			1:       r = 30'h1DAC6705;
			2:       r = 30'h0FADBAFC;
			3:       r = 30'h07F56EA6;
			4:       r = 30'h03FEAB76;
			5:       r = 30'h01FFD55B;
			6:       r = 30'h00FFFAAA;
			7:       r = 30'h007FFF55;
			8:       r = 30'h003FFFEA;
			9:       r = 30'h001FFFFD;
			10:      r = 30'h000FFFFF;
			11:      r = 30'h0007FFFF;
			12:      r = 30'h0003FFFF;
			13:      r = 30'h0001FFFF;
			14:      r = 30'h0000FFFF;
			15:      r = 30'h00007FFF;
			16:      r = 30'h00003FFF;
			17:      r = 30'h00001FFF;
			18:      r = 30'h00000FFF;
			19:      r = 30'h000007FF;
			20:      r = 30'h000003FF;
			21:      r = 30'h000001FF;
			22:      r = 30'h000000FF;
			23:      r = 30'h0000007F;
			24:      r = 30'h0000003F;
			25:      r = 30'h0000001F;
			26:      r = 30'h0000000F;
			27:      r = 30'h00000008;
			28:      r = 30'h00000004;
			29:      r = 30'h00000002;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ellipsoid_point_distance.sv
// throughput: one request per cycle unless a result stalls; 144 register stages,
// one per CORDIC rotation, per root bit pair and per quotient bit, plus split
// multiplier stages and stages for the input, clamp, leg selection and output
// a stall on a valid result freezes the whole pipe and stalls the request side
// reset (arst_n low) clears the stage valid bits only; data registers are not reset
`default_nettype none

module ellipsoid_point_distance (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         pair_valid,
	output logic        pair_stall,
	input  wire  [30:0] lat_a,
	input  wire  [31:0] lon_a,
	input  wire  [30:0] lat_b,
	input  wire  [31:0] lon_b,
	output logic        dist_valid,
	input  wire         dist_stall,
	output logic [32:0] distance_cm
);
	import epd_pkg::*;

	// stage map
	localparam int ST_TH  = 3;                  // angle in Q2.30 rad
	localparam int ST_CE  = ST_TH + CORDIC_N;   // end of rotations
	localparam int ST_CL  = ST_CE + 1;          // clamped sin, cos
	localparam int ST_S2  = ST_CL + 1;          // sin^2
	localparam int ST_T   = ST_S2 + 1;          // e2 sin^2
	localparam int ST_W2  = ST_T + 1;           // w2, first root stage input
	localparam int ST_R1  = ST_W2 + SQ1_K;      // W
	localparam int ST_WW  = ST_R1 + 1;          // W^2
	localparam int ST_W3  = ST_WW + 1;          // W^3, divider input
	localparam int ST_DV  = ST_W3 + DIV_Q;      // N and M quotients
	localparam int ST_NC  = ST_DV + 1;          // N cos P, angle partials
	localparam int ST_U   = ST_NC + 1;          // angle differences
	localparam int ST_XP  = ST_U + 1;           // leg partial products
	localparam int ST_XY  = ST_XP + 1;          // legs x and y
	localparam int ST_SEL = ST_XY + 1;          // saturate / halve decision
	localparam int ST_SQ  = ST_SEL + 1;         // leg squares
	localparam int ST_SUM = ST_SQ + 1;          // sum of squares
	localparam int ST_R2  = ST_SUM + SQ2_K;     // root of the sum
	localparam int ST_OUT = ST_R2 + 1;          // output register
	localparam int CW     = 33;                 // rotation datapath width

	// global advance: the pipe only holds when a finished result is stalled
	logic en;
	logic vld_s [1:ST_OUT];

	assign en         = !(vld_s[ST_OUT] && dist_stall);
	assign pair_stall = !en;
	assign dist_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_OUT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pair_valid;
			for (int k = 2; k <= ST_OUT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------------------------------------------------------
	// s1: sums and differences of the raw coordinates
	// ---------------------------------------------------------------
	logic [31:0] hs_s1;
	logic [31:0] dla_s1;
	logic [32:0] dlo_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s1  <= {lat_a[30], lat_a} + {lat_b[30], lat_b};
			dla_s1 <= {lat_a[30], lat_a} - {lat_b[30], lat_b};
			dlo_s1 <= {lon_a[31], lon_a} - {lon_b[31], lon_b};
		end
	end

	// ---------------------------------------------------------------
	// s2: magnitudes; latitude sum folds back past 180 degrees
	// ---------------------------------------------------------------
	logic [31:0] habs, hfold, dla_mag;
	logic [32:0] dlo_mag;
	logic [30:0] h_s2;
	logic [30:0] dlat_s [2:ST_DV];
	logic [31:0] dlon_s [2:ST_DV];

	always_comb begin
		habs    = hs_s1[31] ? (~hs_s1 + 32'd1) : hs_s1;
		hfold   = (habs > H_FOLD) ? (H_WRAP - habs) : habs;
		dla_mag = dla_s1[31] ? (~dla_s1 + 32'd1) : dla_s1;
		dlo_mag = dlo_s1[32] ? (~dlo_s1 + 33'd1) : dlo_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2      <= hfold[30:0];
			dlat_s[2] <= dla_mag[30:0];
			dlon_s[2] <= dlo_mag[31:0];
			for (int k = 3; k <= ST_DV; k++) begin
				dlat_s[k] <= dlat_s[k-1];
				dlon_s[k] <= dlon_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// s3: mean latitude angle, loaded as the rotation start vector
	// ---------------------------------------------------------------
	logic [62:0] th_prod;
	logic signed [CW-1:0] cx_s [ST_TH:ST_CE];
	logic signed [CW-1:0] cy_s [ST_TH:ST_CE];
	logic signed [CW-1:0] cz_s [ST_TH:ST_CE];

	assign th_prod = 63'(h_s2) * 63'(CA);

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[ST_TH] <= signed'(CW'(CORDIC_K));
			cy_s[ST_TH] <= '0;
			cz_s[ST_TH] <= signed'({2'b00, th_prod[62:32]});
		end
	end

	// one rotation per stage, shifts round toward minus infinity
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
		logic signed [CW-1:0] dx, dy, za;

		assign dx = cy_s[ST_TH+i] >>> i;
		assign dy = cx_s[ST_TH+i] >>> i;
		assign za = signed'({3'b000, epd_atan(i)});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[ST_TH+i][CW-1]) begin
					cx_s[ST_TH+i+1] <= cx_s[ST_TH+i] - dx;
					cy_s[ST_TH+i+1] <= cy_s[ST_TH+i] + dy;
					cz_s[ST_TH+i+1] <= cz_s[ST_TH+i] - za;
				end else begin
					cx_s[ST_TH+i+1] <= cx_s[ST_TH+i] + dx;
					cy_s[ST_TH+i+1] <= cy_s[ST_TH+i] - dy;
					cz_s[ST_TH+i+1] <= cz_s[ST_TH+i] + za;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// clamp to [0, 1] in Q30; cos rides along to the radius product
	// ---------------------------------------------------------------
	logic [30:0] sn_c, cs_c;
	logic [30:0] sn_s34;
	logic [30:0] cs_s [ST_CL:ST_DV];

	always_comb begin
		if (cy_s[ST_CE][CW-1])              sn_c = '0;
		else if (cy_s[ST_CE][CW-2:30] != '0) sn_c = ONE30;
		else                                sn_c = cy_s[ST_CE][30:0];
		if (cx_s[ST_CE][CW-1])              cs_c = '0;
		else if (cx_s[ST_CE][CW-2:30] != '0) cs_c = ONE30;
		else                                cs_c = cx_s[ST_CE][30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s34       <= sn_c;
			cs_s[ST_CL] <= cs_c;
			for (int k = ST_CL + 1; k <= ST_DV; k++) cs_s[k] <= cs_s[k-1];
		end
	end

	// ---------------------------------------------------------------
	// w2 = 1 - e2 sin^2 P
	// ---------------------------------------------------------------
	logic [61:0] s2_prod;
	logic [54:0] e_prod;
	logic [30:0] s2_s35;
	logic [22:0] t_s36;
	logic [2*SQ1_K-1:0] r1_op   [ST_W2:ST_R1];
	logic [SQ1_K+1:0]   r1_rem  [ST_W2:ST_R1];
	logic [SQ1_K-1:0]   r1_root [ST_W2:ST_R1];

	assign s2_prod = 62'(sn_s34) * 62'(sn_s34) + 62'(HALF30);
	assign e_prod  = 55'(E2) * 55'(s2_s35) + 55'(HALF30);

	always_ff @(posedge clk) begin
		if (en) begin
			s2_s35         <= s2_prod[60:30];
			t_s36          <= e_prod[52:30];
			r1_op[ST_W2]   <= {1'b0, ONE30 - {8'd0, t_s36}, 30'd0};
			r1_rem[ST_W2]  <= '0;
			r1_root[ST_W2] <= '0;
		end
	end

	// W = floor sqrt(w2 << 30), one result bit per stage
	for (genvar j = 0; j < SQ1_K; j++) begin : g_rt1
		logic [SQ1_K+1:0] remsh, trial;

		assign remsh = {r1_rem[ST_W2+j][SQ1_K-1:0], r1_op[ST_W2+j][2*SQ1_K-1-2*j -: 2]};
		assign trial = {r1_root[ST_W2+j], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				r1_op[ST_W2+j+1] <= r1_op[ST_W2+j];
				if (remsh >= trial) begin
					r1_rem[ST_W2+j+1]  <= remsh - trial;
					r1_root[ST_W2+j+1] <= {r1_root[ST_W2+j][SQ1_K-2:0], 1'b1};
				end else begin
					r1_rem[ST_W2+j+1]  <= remsh;
					r1_root[ST_W2+j+1] <= {r1_root[ST_W2+j][SQ1_K-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// W^3, then both radius divisions side by side
	// ---------------------------------------------------------------
	logic [61:0] ww_prod, w3_prod;
	logic [30:0] ww_s69, w_s69;
	logic [30:0]      dv_w  [ST_W3:ST_DV];
	logic [30:0]      dv_w3 [ST_W3:ST_DV];
	logic [30:0]      nd_r  [ST_W3:ST_DV];
	logic [30:0]      md_r  [ST_W3:ST_DV];
	logic [DIV_Q-1:0] nd_q  [ST_W3:ST_DV];
	logic [DIV_Q-1:0] md_q  [ST_W3:ST_DV];

	assign ww_prod = 62'(r1_root[ST_R1]) * 62'(r1_root[ST_R1]) + 62'(HALF30);
	assign w3_prod = 62'(ww_s69) * 62'(w_s69) + 62'(HALF30);

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s69       <= ww_prod[60:30];
			w_s69        <= r1_root[ST_R1];
			dv_w[ST_W3]  <= w_s69;
			dv_w3[ST_W3] <= w3_prod[60:30];
			nd_r[ST_W3]  <= N_R0;
			md_r[ST_W3]  <= M_R0;
			nd_q[ST_W3]  <= '0;
			md_q[ST_W3]  <= '0;
		end
	end

	// restoring division, one quotient bit per stage; low dividend bits are zero
	for (genvar k = 0; k < DIV_Q; k++) begin : g_div
		logic [31:0] nsh, msh, nd, md;
		logic        nge, mge;

		assign nsh = {nd_r[ST_W3+k], 1'b0};
		assign msh = {md_r[ST_W3+k], 1'b0};
		assign nd  = {1'b0, dv_w[ST_W3+k]};
		assign md  = {1'b0, dv_w3[ST_W3+k]};
		assign nge = (nsh >= nd);
		assign mge = (msh >= md);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_w[ST_W3+k+1]  <= dv_w[ST_W3+k];
				dv_w3[ST_W3+k+1] <= dv_w3[ST_W3+k];
				nd_r[ST_W3+k+1]  <= nge ? 31'(nsh - nd) : nsh[30:0];
				md_r[ST_W3+k+1]  <= mge ? 31'(msh - md) : msh[30:0];
				nd_q[ST_W3+k+1]  <= {nd_q[ST_W3+k][DIV_Q-2:0], nge};
				md_q[ST_W3+k+1]  <= {md_q[ST_W3+k][DIV_Q-2:0], mge};
			end
		end
	end

	// ---------------------------------------------------------------
	// N cos P and the angle differences in centiradians
	// ---------------------------------------------------------------
	logic [64:0] nc_prod;
	logic [33:0] nc_s105, mq_s105;
	logic [50:0] ulh_s105, ull_s105;
	logic [51:0] ugh_s105, ugl_s105;

	assign nc_prod = 65'(nd_q[ST_DV]) * 65'(cs_s[ST_DV]);

	always_ff @(posedge clk) begin
		if (en) begin
			nc_s105  <= nc_prod[63:30];
			mq_s105  <= md_q[ST_DV];
			ulh_s105 <= 51'(dlat_s[ST_DV]) * 51'(CD_HI);
			ull_s105 <= 51'(dlat_s[ST_DV]) * 51'(CD_LO);
			ugh_s105 <= 52'(dlon_s[ST_DV]) * 52'(CD_HI);
			ugl_s105 <= 52'(dlon_s[ST_DV]) * 52'(CD_LO);
		end
	end

	logic [71:0] ulat_sum, ulon_sum;
	logic [38:0] ulat_s106;
	logic [39:0] ulon_s106;
	logic [33:0] nc_s106, mq_s106;

	assign ulat_sum = 72'({ulh_s105, 20'd0}) + 72'(ull_s105);
	assign ulon_sum = 72'({ugh_s105, 20'd0}) + 72'(ugl_s105);

	always_ff @(posedge clk) begin
		if (en) begin
			ulat_s106 <= ulat_sum[70:32];
			ulon_s106 <= ulon_sum[71:32];
			nc_s106   <= nc_s105;
			mq_s106   <= mq_s105;
		end
	end

	// ---------------------------------------------------------------
	// legs x = M dP and y = N cos P dL in cm, split products
	// ---------------------------------------------------------------
	logic [53:0] xl_s107, yl_s107, yh_s107;
	logic [52:0] xh_s107;

	always_ff @(posedge clk) begin
		if (en) begin
			xl_s107 <= 54'(mq_s106) * 54'(ulat_s106[19:0]);
			xh_s107 <= 53'(mq_s106) * 53'(ulat_s106[38:20]);
			yl_s107 <= 54'(nc_s106) * 54'(ulon_s106[19:0]);
			yh_s107 <= 54'(nc_s106) * 54'(ulon_s106[39:20]);
		end
	end

	logic [73:0] x_sum, y_sum;
	logic [32:0] x_s108;
	logic [33:0] y_s108;

	assign x_sum = 74'({xh_s107, 20'd0}) + 74'(xl_s107);
	assign y_sum = 74'({yh_s107, 20'd0}) + 74'(yl_s107);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s108 <= x_sum[72:40];
			y_s108 <= y_sum[73:40];
		end
	end

	// saturate on a long leg; halve both legs when either reaches 2^31
	logic        sat_c, big_c;
	logic [31:0] a_s109, b_s109;
	logic        sat_s [ST_SEL:ST_R2];
	logic        big_s [ST_SEL:ST_R2];

	assign sat_c = (34'(x_s108) > 34'(DIST_MAX)) || (y_s108 > 34'(DIST_MAX));
	assign big_c = (x_s108[32:31] != 2'b00) || (y_s108[33:31] != 3'b000);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s109        <= big_c ? x_s108[32:1] : x_s108[31:0];
			b_s109        <= big_c ? y_s108[32:1] : y_s108[31:0];
			sat_s[ST_SEL] <= sat_c;
			big_s[ST_SEL] <= big_c;
			for (int k = ST_SEL + 1; k <= ST_R2; k++) begin
				sat_s[k] <= sat_s[k-1];
				big_s[k] <= big_s[k-1];
			end
		end
	end

	logic [63:0] aa_s110, bb_s110;
	logic [2*SQ2_K-1:0] r2_op   [ST_SUM:ST_R2];
	logic [SQ2_K+1:0]   r2_rem  [ST_SUM:ST_R2];
	logic [SQ2_K-1:0]   r2_root [ST_SUM:ST_R2];

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s110         <= 64'(a_s109) * 64'(a_s109);
			bb_s110         <= 64'(b_s109) * 64'(b_s109);
			r2_op[ST_SUM]   <= aa_s110 + bb_s110;
			r2_rem[ST_SUM]  <= '0;
			r2_root[ST_SUM] <= '0;
		end
	end

	// hypotenuse root, one bit per stage
	for (genvar j = 0; j < SQ2_K; j++) begin : g_rt2
		logic [SQ2_K+1:0] remsh, trial;

		assign remsh = {r2_rem[ST_SUM+j][SQ2_K-1:0], r2_op[ST_SUM+j][2*SQ2_K-1-2*j -: 2]};
		assign trial = {r2_root[ST_SUM+j], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				r2_op[ST_SUM+j+1] <= r2_op[ST_SUM+j];
				if (remsh >= trial) begin
					r2_rem[ST_SUM+j+1]  <= remsh - trial;
					r2_root[ST_SUM+j+1] <= {r2_root[ST_SUM+j][SQ2_K-2:0], 1'b1};
				end else begin
					r2_rem[ST_SUM+j+1]  <= remsh;
					r2_root[ST_SUM+j+1] <= {r2_root[ST_SUM+j][SQ2_K-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// undo the halving, saturate, output register
	// ---------------------------------------------------------------
	logic [32:0] dd;
	logic [32:0] dist_s144;

	assign dd = big_s[ST_R2] ? {r2_root[ST_R2], 1'b0} : {1'b0, r2_root[ST_R2]};

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s144 <= (sat_s[ST_R2] || (dd > DIST_MAX)) ? DIST_MAX : dd;
		end
	end

	assign distance_cm = dist_s144;

endmodule

`default_nettype wire

>>> rtl/core/epd_checker.sv
`default_nettype none

module epd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        pair_valid,
	input wire        pair_stall,
	input wire        dist_valid,
	input wire        dist_stall,
	input wire [32:0] distance_cm
);
	import epd_pkg::*;

	// distance never passes the saturation point
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> (distance_cm <= DIST_MAX))
		else $error("distance above saturation");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dist_valid && dist_stall) |=> (dist_valid && $stable(distance_cm)))
		else $error("stalled result changed");

	// request side only holds off while a finished result is stalled
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (dist_valid && dist_stall))
		else $error("request stalled without output stall");

endmodule

bind ellipsoid_point_distance epd_checker u_epd_checker (.*);

`default_nettype wire

>>> dv/ellipsoid_point_distance_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module ellipsoid_point_distance_tb;

	// fixed-point constants, kept apart from the design's own package
	localparam logic [63:0] PI62_K   = 64'hC90FDAA22168C234;
	localparam logic [63:0] RAD_CA   = PI62_K / 64'd3600000000;
	localparam logic [63:0] CRAD_CD  = PI62_K / 64'd18000000;
	localparam logic [63:0] ECC2     = (64'd1073741824 * 64'd6674 + 64'd500000) / 64'd1000000;
	localparam logic [63:0] Q30_ONE  = 64'd1073741824;
	localparam logic [63:0] Q30_HALF = 64'd536870912;
	localparam logic [63:0] MERID_R  = 64'd6334834;
	localparam logic [63:0] PRIME_R  = 64'd6377397;
	localparam longint      ROT_GAIN = 64'h26DD3B6A;
	localparam logic [63:0] SAT_CM   = 64'd4500000000;
	localparam int          PIPE_LAT = 143;
	localparam int          CYC_LIMIT = 600000;

	typedef struct packed {
		logic [30:0] lat_a;
		logic [31:0] lon_a;
		logic [30:0] lat_b;
		logic [31:0] lon_b;
	} pair_t;

	logic        clk;
	logic        arst_n;
	logic        pair_valid;
	logic        pair_stall;
	logic [30:0] lat_a;
	logic [31:0] lon_a;
	logic [30:0] lat_b;
	logic [31:0] lon_b;
	logic        dist_valid;
	logic        dist_stall;
	logic [32:0] distance_cm;

	pair_t       pend_pairs[$];
	logic [32:0] dist_expected[$];
	longint      atan_q30[30];
	int          mismatches;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        long_hold;
	int          cyc;

	ellipsoid_point_distance u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.lat_a(lat_a),
		.lon_a(lon_a),
		.lat_b(lat_b),
		.lon_b(lon_b),
		.dist_valid(dist_valid),
		.dist_stall(dist_stall),
		.distance_cm(distance_cm)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// full-width product, then a right shift
	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
		input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> sh);
	endfunction

	// floor square root, bit-pair method
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// hubeny distance in cm for one request
	function automatic logic [32:0] hubeny_cm(input pair_t p);
		longint      la, oa, lb, ob, sum, df;
		logic [63:0] h, dlat, dlon, theta;
		longint      cx, cy, cz, dx, dy, sn, cs;
		logic [63:0] s2, w2, w, w3, nq, mq, nc, ulat, ulon, x, y, d, ha, hb;
		la = longint'($signed(p.lat_a));
		oa = longint'($signed(p.lon_a));
		lb = longint'($signed(p.lat_b));
		ob = longint'($signed(p.lon_b));
		sum = la + lb;
		h = (sum < 0) ? -sum : sum;
		df = la - lb;
		dlat = (df < 0) ? -df : df;
		df = oa - ob;
		dlon = (df < 0) ? -df : df;
		// mean latitude folds past the pole
		if (h > 64'd1800000000)
			h = 64'd3600000000 - h;
		theta = mul_shr(h, RAD_CA, 32);
		cx = ROT_GAIN;
		cy = 0;
		cz = longint'(theta);
		for (int i = 0; i < 30; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cz >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				cz = cz - atan_q30[i];
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				cz = cz + atan_q30[i];
			end
		end
		sn = (cy < 0) ? 0 : ((cy > longint'(Q30_ONE)) ? longint'(Q30_ONE) : cy);
		cs = (cx < 0) ? 0 : ((cx > longint'(Q30_ONE)) ? longint'(Q30_ONE) : cx);
		s2 = (64'(sn) * 64'(sn) + Q30_HALF) >> 30;
		w2 = Q30_ONE - ((ECC2 * s2 + Q30_HALF) >> 30);
		w = floor_sqrt(w2 << 30);
		w3 = ((((w * w + Q30_HALF) >> 30) * w) + Q30_HALF) >> 30;
		if (w == 0)
			w = 1;
		if (w3 == 0)
			w3 = 1;
		nq = (PRIME_R << 40) / w;
		mq = (MERID_R << 40) / w3;
		nc = mul_shr(nq, 64'(cs), 30);
		ulat = mul_shr(dlat, CRAD_CD, 32);
		ulon = mul_shr(dlon, CRAD_CD, 32);
		x = mul_shr(mq, ulat, 40);
		y = mul_shr(nc, ulon, 40);
		if (x > SAT_CM || y > SAT_CM) begin
			d = SAT_CM;
		end else if (x >= (64'd1 << 31) || y >= (64'd1 << 31)) begin
			// large legs: halve, root, double
			ha = x >> 1;
			hb = y >> 1;
			d = floor_sqrt(ha * ha + hb * hb) << 1;
		end else begin
			d = floor_sqrt(x * x + y * y);
		end
		if (d > SAT_CM)
			d = SAT_CM;
		return d[32:0];
	endfunction

	task automatic mismatch_report(input logic [32:0] got, input logic [32:0] want);
		$display("mismatch at cycle %0d: distance_cm got %0d want %0d", cyc, got, want);
		mismatches++;
	endtask

	task automatic add_pair(input longint la, input longint oa, input longint lb,
		input longint ob);
		pair_t p;
		p.lat_a = la[30:0];
		p.lon_a = oa[31:0];
		p.lat_b = lb[30:0];
		p.lon_b = ob[31:0];
		pend_pairs.insert(pend_pairs.size(), p);
	endtask

	// random request: nearby points most often, else points anywhere or raw bit patterns
	task automatic add_random_pair();
		int     kind;
		longint la, oa, lb, ob;
		kind = $urandom_range(99);
		la = longint'($urandom_range(1800000000)) - 900000000;
		oa = longint'($urandom_range(3600000000)) - 1800000000;
		if (kind < 45) begin
			lb = la + longint'($urandom_range(2000000)) - 1000000;
			ob = oa + longint'($urandom_range(2000000)) - 1000000;
		end else if (kind < 80) begin
			lb = longint'($urandom_range(1800000000)) - 900000000;
			ob = longint'($urandom_range(3600000000)) - 1800000000;
		end else begin
			la = longint'($urandom);
			oa = longint'($urandom);
			lb = longint'($urandom);
			ob = longint'($urandom);
		end
		add_pair(la, oa, lb, ob);
	endtask

	// wait until the sender has handed over everything queued
	task automatic wait_sent();
		while (pend_pairs.size() != 0 || pair_valid)
			@(posedge clk);
	endtask

	// global cycle limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// request driver: holds payload while stalled, gaps at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid <= 1'b0;
			lat_a <= '0;
			lon_a <= '0;
			lat_b <= '0;
			lon_b <= '0;
		end else begin
			// a taken request gets its expected distance right away
			if (pair_valid && !pair_stall)
				dist_expected.insert(dist_expected.size(),
					hubeny_cm({lat_a, lon_a, lat_b, lon_b}));
			if (!pair_valid || !pair_stall) begin
				if (pend_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pair_t p;
					p = pend_pairs.pop_front();
					lat_a <= p.lat_a;
					lon_a <= p.lon_a;
					lat_b <= p.lat_b;
					lon_b <= p.lon_b;
					pair_valid <= 1'b1;
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor plus random stall on the result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_stall <= 1'b0;
		end else begin
			if (dist_valid && !dist_stall) begin
				if (dist_expected.size() == 0) begin
					// result with no request behind it
					mismatch_report(distance_cm, 33'bx);
				end else begin
					logic [32:0] want;
					want = dist_expected.pop_front();
					if (distance_cm !== want)
						mismatch_report(distance_cm, want);
				end
			end
			dist_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		logic [63:0] atan_init[30];
		atan_init = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
			64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
			64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
			64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
			64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004,
			64'h00000002};
		for (int i = 0; i < 30; i++)
			atan_q30[i] = longint'(atan_init[i]);
		mismatches = 0;
		cyc = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, same point, poles, equator, field extremes
		add_pair(0, 0, 0, 0);
		add_pair(351234567, 1397654321, 351234567, 1397654321);
		add_pair(900000000, 0, -900000000, 0);
		add_pair(900000000, 1800000000, 900000000, -1800000000);
		add_pair(-900000000, -1800000000, -900000000, 1800000000);
		add_pair(0, -1800000000, 0, 1800000000);
		add_pair(0, 0, 0, 10);
		add_pair(1, 0, 0, 0);
		// raw extremes of the field widths, out-of-range coordinates
		add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
		add_pair(1073741823, 2147483647, 1073741823, -2147483648);
		add_pair(-1073741824, 0, -1073741824, 0);
		add_pair(-1, -1, -1, -1);
		// mean latitude folds past the pole
		add_pair(1000000000, 5, 950000000, 7);
		add_pair(-1000000000, 0, -900000001, 100000);
		// long legs that stay below saturation
		add_pair(0, 0, 200000000, 0);
		add_pair(0, 0, 0, 200000000);
		add_pair(0, 0, 400000000, 0);
		add_pair(-900000000, 0, 900000000, 1800000000);
		add_pair(450000000, 0, -450000000, 300000000);
		add_pair(899999999, 0, 899999999, 1000000000);
		add_pair(600000000, -1799999999, 600000001, 1799999999);

		// phase: no idling, with one long stretch of held results
		for (int i = 0; i < 480; i++)
			add_random_pair();
		fork
			begin
				repeat (60) @(posedge clk);
				long_hold = 1'b1;
				repeat (500) @(posedge clk);
				long_hold = 1'b0;
			end
		join_none
		wait_sent();
		// sender pauses until the pipe has drained
		while (dist_expected.size() != 0)
			@(posedge clk);

		send_idle_pct = 62;
		for (int i = 0; i < 470; i++)
			add_random_pair();
		wait_sent();

		send_idle_pct = 0;
		recv_stall_pct = 62;
		for (int i = 0; i < 470; i++)
			add_random_pair();
		wait_sent();

		send_idle_pct = 19;
		recv_stall_pct = 19;
		for (int i = 0; i < 470; i++)
			add_random_pair();
		wait_sent();

		while (dist_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 50) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
